// File: rtl/clock_time_stamp_finder_assert.svh
// Assertion macros for the clock time stamp finder.
// Included by the top level; relies on no other file.
`ifndef CLOCK_TIME_STAMP_FINDER_ASSERT_SVH
`define CLOCK_TIME_STAMP_FINDER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CTSF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("clock time stamp finder: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define CTSF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("clock time stamp finder: next-cycle check failed");

`endif

// File: rtl/ctsf_pkg.sv
// Package for the clock time stamp finder: request types, status codes,
// character constants and the digit test. Depends on nothing else.
package ctsf_pkg;

    localparam int unsigned MAX_SENTENCES_DEFAULT = 32'd65535;

    localparam int CHAR_W    = 21;
    localparam int MINUTES_W = 11;
    localparam int NUMBER_W  = 16;
    localparam int DIFF_W    = 12;
    localparam int WINDOW_LEN = 4;
    localparam int FILL_W    = 3;

    localparam logic [CHAR_W-1:0] COLON_CODE = 21'h00003A;
    localparam logic [CHAR_W-1:0] DIGIT_ZERO = 21'h000030;
    localparam logic [CHAR_W-1:0] DIGIT_NINE = 21'h000039;

    localparam logic [6:0] MAX_HOURS   = 7'd23;
    localparam logic [6:0] MAX_MINUTES = 7'd59;

    typedef enum logic [0:0] {
        STATUS_OK       = 1'b0,
        STATUS_BAD_TIME = 1'b1
    } t_status;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              end_of_sentence;
    } t_in;

    typedef struct packed {
        logic [NUMBER_W-1:0]      sentence_number;
        t_status                  status;
        logic signed [DIFF_W-1:0] minutes_difference;
    } t_out;

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return c inside {[DIGIT_ZERO:DIGIT_NINE]};
    endfunction

endpackage

// File: rtl/clock_time_stamp_finder.sv
// Clock time stamp finder: scans a character stream for the first hh:mm
// stamp of each sentence. Uses ctsf_pkg and clock_time_stamp_finder_assert.svh.
//
// Usage:
// Characters arrive on the input channel (i_in_valid / o_in_stall), one per
// request, with end_of_sentence set on the last character of a sentence.
// A request is taken at an edge where i_in_valid is high and o_in_stall low.
// Results leave on the output channel (o_out_valid / i_out_stall); a request
// that completes the first hh:mm window of its sentence gives one result,
// every other request gives none.
// The result is registered in the output register, or in the skid register
// when the output register is held by a stall. One character is taken per
// cycle while o_in_stall is low; the window compare and time arithmetic are
// combinational between the state registers and the output register.
// When the receiver stalls, the output register holds its result and a
// second result is caught by a skid register; only while that skid register
// is full is o_in_stall raised.
// The current time is written through i_cfg_valid / o_cfg_ready /
// i_cfg_data; the port is always ready.
// Synchronous reset clears the window fill, match flag, sentence count,
// current time and both output slots.
`include "clock_time_stamp_finder_assert.svh"

module clock_time_stamp_finder
    import ctsf_pkg::*;
#(
    parameter int unsigned MAX_SENTENCES = MAX_SENTENCES_DEFAULT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in                  i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out                 o_out,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [MINUTES_W-1:0] i_cfg_data
);

    localparam int CNT_W = (MAX_SENTENCES > 1) ? $clog2(MAX_SENTENCES) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_SENTENCES - 1);

    logic [CHAR_W-1:0]    r_window [WINDOW_LEN];
    logic [FILL_W-1:0]    r_fill,    n_fill;
    logic                 r_match_done, n_match_done;
    logic [CNT_W-1:0]     r_count,   n_count;
    logic [MINUTES_W-1:0] r_cur_minutes;

    logic r_out_valid,  n_out_valid;
    t_out r_out,        n_out;
    logic r_skid_valid, n_skid_valid;
    t_out r_skid,       n_skid;

    logic                 w_in_fire;
    logic                 w_out_fire;
    logic                 w_hit;
    logic [3:0]           w_h_tens, w_h_ones, w_m_tens, w_m_ones;
    logic [6:0]           w_hours, w_mins;
    logic [MINUTES_W-1:0] w_total;
    logic [DIFF_W-1:0]    w_diff;
    logic [CNT_W:0]       w_number;
    t_out                 w_res;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign w_in_fire  = i_in_valid && !o_in_stall;
    assign w_out_fire = r_out_valid && !i_out_stall;

    // Window match: oldest two digits, a colon, one digit, then the new character.
    assign w_hit = !r_match_done && (r_fill >= FILL_W'(WINDOW_LEN))
                   && is_digit(r_window[0]) && is_digit(r_window[1])
                   && (r_window[2] == COLON_CODE)
                   && is_digit(r_window[3]) && is_digit(i_in.character);

    assign w_h_tens = r_window[0][3:0];
    assign w_h_ones = r_window[1][3:0];
    assign w_m_tens = r_window[3][3:0];
    assign w_m_ones = i_in.character[3:0];

    assign w_hours  = {3'b000, w_h_tens} * 7'd10 + {3'b000, w_h_ones};
    assign w_mins   = {3'b000, w_m_tens} * 7'd10 + {3'b000, w_m_ones};
    assign w_total  = {4'b0000, w_hours} * 11'd60 + {4'b0000, w_mins};
    assign w_diff   = {1'b0, w_total} - {1'b0, r_cur_minutes};
    assign w_number = {1'b0, r_count} + {{CNT_W{1'b0}}, 1'b1};

    always_comb begin
        w_res.sentence_number = NUMBER_W'(w_number);
        if ((w_hours <= MAX_HOURS) && (w_mins <= MAX_MINUTES)) begin
            w_res.status             = STATUS_OK;
            w_res.minutes_difference = $signed(w_diff);
        end else begin
            w_res.status             = STATUS_BAD_TIME;
            w_res.minutes_difference = '0;
        end
    end

    // Sentence state
    always_comb begin
        n_fill       = r_fill;
        n_match_done = r_match_done;
        n_count      = r_count;
        if (w_in_fire) begin
            if (w_hit) begin
                n_match_done = 1'b1;
            end
            if (r_fill < FILL_W'(WINDOW_LEN)) begin
                n_fill = r_fill + FILL_W'(1);
            end
            if (i_in.end_of_sentence) begin
                n_fill       = '0;
                n_match_done = 1'b0;
                if (r_count < CNT_LAST) begin
                    n_count = r_count + CNT_W'(1);
                end
            end
        end
    end

    // Output register with skid stage
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (!r_out_valid || w_out_fire) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = w_in_fire && w_hit;
                n_out       = w_res;
            end
        end else if (w_in_fire && w_hit) begin
            n_skid_valid = 1'b1;
            n_skid       = w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill        <= '0;
            r_match_done  <= 1'b0;
            r_count       <= '0;
            r_cur_minutes <= '0;
            r_out_valid   <= 1'b0;
            r_skid_valid  <= 1'b0;
        end else begin
            r_fill       <= n_fill;
            r_match_done <= n_match_done;
            r_count      <= n_count;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cur_minutes <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
        if (w_in_fire) begin
            r_window[0] <= r_window[1];
            r_window[1] <= r_window[2];
            r_window[2] <= r_window[3];
            r_window[3] <= i_in.character;
        end
    end

    `CTSF_ASSERT_NOW(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `CTSF_ASSERT_NOW(a_fill_saturates, i_clk, i_rst_n, 1'b1, r_fill <= FILL_W'(WINDOW_LEN))
    `CTSF_ASSERT_NEXT(a_sentence_closes, i_clk, i_rst_n, w_in_fire && i_in.end_of_sentence,
                      !r_match_done && (r_fill == '0))
    `CTSF_ASSERT_NEXT(a_hit_marks_done, i_clk, i_rst_n,
                      w_in_fire && w_hit && !i_in.end_of_sentence, r_match_done && r_out_valid)

endmodule
